### rtl/vtrp_pkg.sv
// Shared types, constants and width helpers for the vertex projection block.
// No dependencies.
package vtrp_pkg;

  localparam int COORD_WIDTH_DEF    = 16;
  localparam int COEF_FRAC_BITS_DEF = 12;
  localparam int CFG_DATA_W         = 48;
  localparam int CFG_ADDR_W         = 3;

  localparam logic [CFG_ADDR_W-1:0] CFG_ROT_X   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROT_Y   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROT_Z   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRANS   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_DIST    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_HALF_W  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_HALF_H  = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_PIX_SCL = 3'd7;

  typedef struct packed {
    logic [47:0] rot_x;
    logic [47:0] rot_y;
    logic [47:0] rot_z;
    logic [47:0] trans;
    logic [7:0]  distance;
    logic [15:0] half_w;
    logic [15:0] half_h;
    logic [31:0] scale;
  } vtrp_cfg_t;

  // camera coordinate width: three products plus translation, with headroom
  function automatic int cam_w(input int cw, input int frac);
    cam_w = ((cw + 16) > (16 + frac) ? (cw + 16) : (16 + frac)) + 2;
  endfunction

  // numerator magnitude width: c*d*256 + half*z
  function automatic int num_w(input int cw, input int frac);
    num_w = cam_w(cw, frac) + 18;
  endfunction

endpackage

### rtl/vtrp_xform.sv
// Camera transform: rotation products, then sum with translation (two stages).
// Depends on vtrp_pkg.
module vtrp_xform #(
  parameter int COORD_WIDTH    = vtrp_pkg::COORD_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = vtrp_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [COORD_WIDTH-1:0] vx,
  input  logic [COORD_WIDTH-1:0] vy,
  input  logic [COORD_WIDTH-1:0] vz,
  input  vtrp_pkg::vtrp_cfg_t cfg,
  output logic                out_valid,
  output logic signed [vtrp_pkg::cam_w(COORD_WIDTH, COEF_FRAC_BITS)-1:0] cx,
  output logic signed [vtrp_pkg::cam_w(COORD_WIDTH, COEF_FRAC_BITS)-1:0] cy,
  output logic signed [vtrp_pkg::cam_w(COORD_WIDTH, COEF_FRAC_BITS)-1:0] cz
);
  import vtrp_pkg::*;

  localparam int CAM_W = cam_w(COORD_WIDTH, COEF_FRAC_BITS);
  localparam int PW    = COORD_WIDTH + 16;
  localparam int TW    = 16 + COEF_FRAC_BITS;

  logic signed [COORD_WIDTH-1:0] v [3];
  logic [47:0]                   col [3];
  logic signed [PW-1:0]          p_r [3][3];
  logic signed [TW-1:0]          t_r [3];
  logic signed [CAM_W-1:0]       c_r [3];
  logic                          v1_r, v2_r;

  assign v[0]   = $signed(vx);
  assign v[1]   = $signed(vy);
  assign v[2]   = $signed(vz);
  assign col[0] = cfg.rot_x;
  assign col[1] = cfg.rot_y;
  assign col[2] = cfg.rot_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 3; i++) begin
          p_r[a][i] <= $signed(col[a][16*i +: 16]) * v[i];
        end
        t_r[a] <= $signed({cfg.trans[16*a +: 16], {COEF_FRAC_BITS{1'b0}}});
        c_r[a] <= CAM_W'(p_r[a][0]) + CAM_W'(p_r[a][1]) + CAM_W'(p_r[a][2])
                + CAM_W'(t_r[a]);
      end
    end
  end

  assign out_valid = v2_r;
  assign cx = c_r[0];
  assign cy = c_r[1];
  assign cz = c_r[2];

endmodule

### rtl/vtrp_num.sv
// Numerator/denominator build, depth, and scale multiply (three stages).
// Depends on vtrp_pkg.
module vtrp_num #(
  parameter int COORD_WIDTH    = vtrp_pkg::COORD_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = vtrp_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [vtrp_pkg::cam_w(COORD_WIDTH, COEF_FRAC_BITS)-1:0] cx,
  input  logic signed [vtrp_pkg::cam_w(COORD_WIDTH, COEF_FRAC_BITS)-1:0] cy,
  input  logic signed [vtrp_pkg::cam_w(COORD_WIDTH, COEF_FRAC_BITS)-1:0] cz,
  input  vtrp_pkg::vtrp_cfg_t cfg,
  output logic                out_valid,
  output logic [vtrp_pkg::num_w(COORD_WIDTH, COEF_FRAC_BITS)+15:0] nx,
  output logic [vtrp_pkg::num_w(COORD_WIDTH, COEF_FRAC_BITS)+15:0] ny,
  output logic [vtrp_pkg::cam_w(COORD_WIDTH, COEF_FRAC_BITS)+11:0] den,
  output logic                neg_x,
  output logic                neg_y,
  output logic [COORD_WIDTH-1:0] dep,
  output logic                dep_sat,
  output logic                zero
);
  import vtrp_pkg::*;

  localparam int CAM_W = cam_w(COORD_WIDTH, COEF_FRAC_BITS);
  localparam int NUM_W = num_w(COORD_WIDTH, COEF_FRAC_BITS);
  localparam int MW    = CAM_W + 9;
  localparam int HW    = CAM_W + 17;
  localparam int DW    = CAM_W + 12;

  // stage 3
  logic signed [MW-1:0]    mx_r, my_r;
  logic signed [HW-1:0]    hx_r, hy_r;
  logic signed [CAM_W-1:0] z3_r;
  // stage 4
  logic [NUM_W-1:0]        ax_r, ay_r;
  logic [DW-1:0]           d4_r, d5_r;
  logic                    ngx4_r, ngy4_r, ngx5_r, ngy5_r;
  logic [COORD_WIDTH-1:0]  dep4_r, dep5_r;
  logic                    ds4_r, ds5_r, z4_r, z5_r;
  // stage 5
  logic [NUM_W+15:0]       nx_r, ny_r;
  logic                    v3_r, v4_r, v5_r;

  logic signed [NUM_W-1:0] num_x, num_y;
  logic signed [CAM_W-1:0] zq, hi_c, lo_c, bias;
  logic [CAM_W-1:0]        zabs;

  assign hi_c = $signed({{(CAM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
  assign lo_c = -hi_c - CAM_W'(1);
  assign bias = $signed({{(CAM_W-COEF_FRAC_BITS){1'b0}}, {COEF_FRAC_BITS{1'b1}}});

  always_comb begin
    num_x = (NUM_W'(mx_r) <<< 8) + NUM_W'(hx_r);
    num_y = (NUM_W'(my_r) <<< 8) + NUM_W'(hy_r);
    zabs  = z3_r[CAM_W-1] ? CAM_W'(-z3_r) : CAM_W'(z3_r);
    // truncate toward zero
    zq    = z3_r[CAM_W-1] ? ((z3_r + bias) >>> COEF_FRAC_BITS)
                          : (z3_r >>> COEF_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v3_r <= in_valid;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r <= cx * $signed({1'b0, cfg.distance});
      my_r <= cy * $signed({1'b0, cfg.distance});
      hx_r <= $signed({1'b0, cfg.half_w}) * cz;
      hy_r <= $signed({1'b0, cfg.half_h}) * cz;
      z3_r <= cz;

      ax_r   <= num_x[NUM_W-1] ? NUM_W'(-num_x) : NUM_W'(num_x);
      ay_r   <= num_y[NUM_W-1] ? NUM_W'(-num_y) : NUM_W'(num_y);
      ngx4_r <= num_x[NUM_W-1] ^ z3_r[CAM_W-1];
      ngy4_r <= num_y[NUM_W-1] ^ z3_r[CAM_W-1];
      d4_r   <= {zabs, 12'b0};
      z4_r   <= (z3_r == '0);
      if (zq > hi_c) begin
        dep4_r <= hi_c[COORD_WIDTH-1:0];
        ds4_r  <= 1'b1;
      end else if (zq < lo_c) begin
        dep4_r <= lo_c[COORD_WIDTH-1:0];
        ds4_r  <= 1'b1;
      end else begin
        dep4_r <= zq[COORD_WIDTH-1:0];
        ds4_r  <= 1'b0;
      end

      nx_r   <= ax_r * cfg.scale[15:0];
      ny_r   <= ay_r * cfg.scale[31:16];
      d5_r   <= d4_r;
      ngx5_r <= ngx4_r;
      ngy5_r <= ngy4_r;
      dep5_r <= dep4_r;
      ds5_r  <= ds4_r;
      z5_r   <= z4_r;
    end
  end

  assign out_valid = v5_r;
  assign nx      = nx_r;
  assign ny      = ny_r;
  assign den     = d5_r;
  assign neg_x   = ngx5_r;
  assign neg_y   = ngy5_r;
  assign dep     = dep5_r;
  assign dep_sat = ds5_r;
  assign zero    = z5_r;

endmodule

### rtl/vtrp_div.sv
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit
// per stage plus an overflow stage; carries a side word along. Depends on vtrp_pkg.
module vtrp_div #(
  parameter int QW = vtrp_pkg::COORD_WIDTH_DEF,
  parameter int NW = 70,
  parameter int DW = 48,
  parameter int SW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] n0,
  input  logic [NW-1:0] n1,
  input  logic [DW-1:0] d,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [QW-1:0] q0,
  output logic [QW-1:0] q1,
  output logic          ovf0,
  output logic          ovf1,
  output logic [SW-1:0] side_out
);
  import vtrp_pkg::*;

  localparam int RW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [RW-1:0] rem_r  [QW+1][2];
  logic [QW-1:0] q_r    [QW+1][2];
  logic          ovf_r  [QW+1][2];
  logic [DW-1:0] d_r    [QW+1];
  logic [SW-1:0] side_r [QW+1];
  logic          vld_r  [QW+1];

  logic [RW-1:0] n_in [2];
  assign n_in[0] = RW'(n0);
  assign n_in[1] = RW'(n1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= QW; j++) vld_r[j] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int j = 1; j <= QW; j++) vld_r[j] <= vld_r[j-1];
    end
  end

  // overflow stage: quotient would not fit QW bits
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        rem_r[0][l] <= n_in[l];
        q_r[0][l]   <= '0;
        ovf_r[0][l] <= n_in[l] >= (RW'(d) << QW);
      end
      d_r[0]    <= d;
      side_r[0] <= side;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_stage
    logic [RW-1:0] dsh;
    assign dsh = RW'(d_r[j-1]) << (QW - j);
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          if (rem_r[j-1][l] >= dsh) begin
            rem_r[j][l] <= rem_r[j-1][l] - dsh;
            q_r[j][l]   <= q_r[j-1][l] | (QW'(1) << (QW - j));
          end else begin
            rem_r[j][l] <= rem_r[j-1][l];
            q_r[j][l]   <= q_r[j-1][l];
          end
          ovf_r[j][l] <= ovf_r[j-1][l];
        end
        d_r[j]    <= d_r[j-1];
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign out_valid = vld_r[QW];
  assign q0        = q_r[QW][0];
  assign q1        = q_r[QW][1];
  assign ovf0      = ovf_r[QW][0];
  assign ovf1      = ovf_r[QW][1];
  assign side_out  = side_r[QW];

endmodule

### rtl/vertex_to_raster_projection.sv
// Perspective vertex projection: world vertex -> raster column/row and depth.
// Pipeline: 2 transform stages, 3 numerator stages, COORD_WIDTH+1 divider stages,
// 1 output register. Throughput one word per cycle; the whole pipeline holds while
// the output word is not taken.
// Synchronous active-low reset clears valid bits and loads register defaults.
module vertex_to_raster_projection #(
  parameter int COORD_WIDTH    = vtrp_pkg::COORD_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = vtrp_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // vertex_x, vertex_y, vertex_z from the lowest bit up
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  input  logic in_tvalid,
  output logic in_tready,
  // raster_column, raster_row, depth from the lowest bit up
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] out_tdata,
  // zero_depth, saturated from the lowest bit up
  output logic [7:0] out_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  input  logic cfg_we,
  input  logic [vtrp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [vtrp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import vtrp_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int CAM_W = cam_w(COORD_WIDTH, COEF_FRAC_BITS);
  localparam int NUM_W = num_w(COORD_WIDTH, COEF_FRAC_BITS);
  localparam int NW    = NUM_W + 16;
  localparam int DW    = CAM_W + 12;
  localparam int SW    = CW + 4;
  localparam int OW    = ((3*CW+7)/8)*8;

  vtrp_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rot_x    <= 48'd4096;
      cfg_r.rot_y    <= 48'd4096 << 16;
      cfg_r.rot_z    <= 48'd4096 << 32;
      cfg_r.trans    <= '0;
      cfg_r.distance <= 8'd1;
      cfg_r.half_w   <= 16'd3200;
      cfg_r.half_h   <= 16'd3200;
      cfg_r.scale    <= {16'd1600, 16'd1600};
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ROT_X:   cfg_r.rot_x    <= cfg_wdata;
        CFG_ROT_Y:   cfg_r.rot_y    <= cfg_wdata;
        CFG_ROT_Z:   cfg_r.rot_z    <= cfg_wdata;
        CFG_TRANS:   cfg_r.trans    <= cfg_wdata;
        CFG_DIST:    cfg_r.distance <= cfg_wdata[7:0];
        CFG_HALF_W:  cfg_r.half_w   <= cfg_wdata[15:0];
        CFG_HALF_H:  cfg_r.half_h   <= cfg_wdata[15:0];
        CFG_PIX_SCL: cfg_r.scale    <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // global advance: every stage moves when the output slot is free or drains
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  logic                    xf_valid;
  logic signed [CAM_W-1:0] cx, cy, cz;

  vtrp_xform #(.COORD_WIDTH(CW), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_xform (
    .clk, .rst_n, .en,
    .in_valid (in_tvalid),
    .vx       (in_tdata[CW-1:0]),
    .vy       (in_tdata[2*CW-1:CW]),
    .vz       (in_tdata[3*CW-1:2*CW]),
    .cfg      (cfg_r),
    .out_valid(xf_valid),
    .cx, .cy, .cz
  );

  logic          nm_valid, neg_x, neg_y, dep_sat, zero;
  logic [NW-1:0] nx, ny;
  logic [DW-1:0] den;
  logic [CW-1:0] dep;

  vtrp_num #(.COORD_WIDTH(CW), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_num (
    .clk, .rst_n, .en,
    .in_valid (xf_valid),
    .cx, .cy, .cz,
    .cfg      (cfg_r),
    .out_valid(nm_valid),
    .nx, .ny, .den, .neg_x, .neg_y, .dep, .dep_sat, .zero
  );

  logic          dv_valid, ovf_x, ovf_y;
  logic [CW-1:0] q_x, q_y;
  logic [SW-1:0] side_o;

  vtrp_div #(.QW(CW), .NW(NW), .DW(DW), .SW(SW)) u_div (
    .clk, .rst_n, .en,
    .in_valid (nm_valid),
    .n0       (nx),
    .n1       (ny),
    .d        (den),
    .side     ({zero, dep_sat, neg_y, neg_x, dep}),
    .out_valid(dv_valid),
    .q0       (q_x),
    .q1       (q_y),
    .ovf0     (ovf_x),
    .ovf1     (ovf_y),
    .side_out (side_o)
  );

  // sign and clamp each axis; a negative result may reach one past max
  logic [CW-1:0] hi_mag, min_mag, col, row;
  logic          sat_x, sat_y;

  assign hi_mag  = {1'b0, {(CW-1){1'b1}}};
  assign min_mag = {1'b1, {(CW-1){1'b0}}};

  always_comb begin
    if (side_o[CW]) begin
      sat_x = ovf_x || (q_x > min_mag);
      col   = sat_x ? min_mag : CW'(-q_x);
    end else begin
      sat_x = ovf_x || (q_x > hi_mag);
      col   = sat_x ? hi_mag : q_x;
    end
    if (side_o[CW+1]) begin
      sat_y = ovf_y || (q_y > min_mag);
      row   = sat_y ? min_mag : CW'(-q_y);
    end else begin
      sat_y = ovf_y || (q_y > hi_mag);
      row   = sat_y ? hi_mag : q_y;
    end
  end

  logic [CW-1:0] col_r, row_r, dep_r;
  logic          zero_r, sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  // zero depth: divider result discarded, all fields zero, no saturation
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r <= side_o[CW+3];
      if (side_o[CW+3]) begin
        col_r <= '0;
        row_r <= '0;
        dep_r <= '0;
        sat_r <= 1'b0;
      end else begin
        col_r <= col;
        row_r <= row;
        dep_r <= side_o[CW-1:0];
        sat_r <= sat_x || sat_y || side_o[CW+2];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OW'({dep_r, row_r, col_r});
  assign out_tuser  = {6'b0, sat_r, zero_r};

endmodule

### tb/sv/tb_top.sv
// Self-checking bench for vertex_to_raster_projection: directed table, then random vertex
// streams over several register settings, scored against an in-bench projection predictor.
// Depends on vtrp_pkg and the block RTL only.
module tb_top;
  import vtrp_pkg::*;

  localparam int LIMIT = 200000;   // cycle ceiling for the whole run
  localparam int HOLD  = 400;      // long receiver hold-off, cycles
  localparam int DRAIN = 40;       // pipeline is 23 deep

  typedef struct packed {
    logic signed [15:0] col;
    logic signed [15:0] row;
    logic signed [15:0] dep;
    logic               zero;
    logic               sat;
  } proj_t;

  typedef struct {
    shortint x, y, z;
    bit      typed;   // expectation written out below, not predicted
    proj_t   e;
  } vec_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [47:0] in_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] out_tdata;
  logic [7:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = CFG_ROT_X;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  vtrp_cfg_t regs;          // shadow of the block's registers
  proj_t     proj_q[$];     // projections still owed by the block
  int        errors = 0;
  int        cycles = 0;
  bit        calm = 1'b0;   // no idling on either side while set
  int        hold_token = 0, hold_seen = 0, hold_left = 0;

  vertex_to_raster_projection uut (.*);

  always #10 clk = ~clk;

  // ---------------- predictor ----------------
  // One raster axis: (256*c*d + half*z) * scale / (4096*z), cut toward zero, clamped.
  function automatic logic signed [15:0] raster(longint c, longint z, longint unsigned half,
                                                longint unsigned scale, inout logic sat);
    longint num, den;
    longint unsigned n, d, q, r, mag;
    bit neg;
    num = c * longint'(regs.distance) * 256 + longint'(half) * z;
    den = z * 4096;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? longint'(-num) : num;
    d = (den < 0) ? longint'(-den) : den;
    q = n / d;
    r = n % d;
    mag = q * scale + (r * scale) / d;
    if (!neg) begin
      if (mag > 32767) begin sat = 1'b1; return 16'sh7fff; end
      return mag[15:0];
    end
    if (mag > 32768) begin sat = 1'b1; return 16'sh8000; end
    return 16'(-longint'(mag));
  endfunction

  function automatic proj_t project_vertex(shortint x, shortint y, shortint z);
    longint v[3];
    longint cam[3];
    logic [47:0] rot[3];
    longint dz;
    proj_t p;
    v[0] = x; v[1] = y; v[2] = z;
    rot[0] = regs.rot_x; rot[1] = regs.rot_y; rot[2] = regs.rot_z;
    for (int a = 0; a < 3; a++) begin
      cam[a] = longint'($signed(regs.trans[16*a +: 16])) * 4096;
      for (int i = 0; i < 3; i++)
        cam[a] += longint'($signed(rot[a][16*i +: 16])) * v[i];
    end
    p = '0;
    p.zero = (cam[2] == 0);
    if (!p.zero) begin
      dz = cam[2] / 4096;
      if (dz > 32767) begin p.dep = 16'sh7fff; p.sat = 1'b1; end
      else if (dz < -32768) begin p.dep = 16'sh8000; p.sat = 1'b1; end
      else p.dep = dz[15:0];
      p.col = raster(cam[0], cam[2], regs.half_w, regs.scale[15:0], p.sat);
      p.row = raster(cam[1], cam[2], regs.half_h, regs.scale[31:16], p.sat);
    end
    return p;
  endfunction

  // ---------------- reporting ----------------
  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH t=%0t %s: got %0d expected %0d", $time, what,
             $signed(got), $signed(want));
    errors++;
  endtask

  // ---------------- register writes, block idle ----------------
  task automatic load_regs(vtrp_cfg_t c);
    logic [CFG_DATA_W-1:0] val[8];
    logic [CFG_ADDR_W-1:0] idx[8];
    idx = '{CFG_ROT_X, CFG_ROT_Y, CFG_ROT_Z, CFG_TRANS, CFG_DIST, CFG_HALF_W, CFG_HALF_H,
            CFG_PIX_SCL};
    val = '{c.rot_x, c.rot_y, c.rot_z, c.trans, 48'(c.distance), 48'(c.half_w),
            48'(c.half_h), 48'(c.scale)};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    regs = c;
  endtask

  function automatic logic [15:0] coef_near(bit diag);
    // diagonal near 1.0, off-diagonal within +-0.5
    if (diag) return 16'(4096 + int'($urandom_range(0, 2048)) - 1024);
    return 16'(int'($urandom_range(0, 4095)) - 2048);
  endfunction

  function automatic vtrp_cfg_t pick_cfg(int ph);
    vtrp_cfg_t c;
    case (ph)
      3: c = '1;                                // every register at its top
      7: c = '0;                                // all zero: depth always zero
      11: begin                                 // camera z = world x / 4096: tiny depths
        c = '0;
        c.rot_x = 48'h1000; c.rot_y = 48'h1000_0000; c.rot_z = 48'd1;
        c.distance = 8'd1; c.half_w = 16'd3200; c.half_h = 16'd3200;
        c.scale = {16'd1600, 16'd1600};
      end
      default:
        if (ph % 2) begin
          c = vtrp_cfg_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom});
        end else begin
          c.rot_x = {coef_near(0), coef_near(0), coef_near(1)};
          c.rot_y = {coef_near(0), coef_near(1), coef_near(0)};
          c.rot_z = {coef_near(1), coef_near(0), coef_near(0)};
          c.trans = {16'($urandom_range(256, 8192)), 16'($urandom), 16'($urandom)};
          c.distance = 8'($urandom_range(1, 255));
          c.half_w = 16'($urandom);
          c.half_h = 16'($urandom);
          c.scale = {16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000))};
        end
    endcase
    return c;
  endfunction

  // ---------------- sender ----------------
  task automatic send_vertex(shortint x, shortint y, shortint z, bit typed, proj_t e);
    if (!calm && $urandom_range(99) < 11) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tdata <= {16'(z), 16'(y), 16'(x)};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    proj_q.push_back(typed ? e : project_vertex(x, y, z));
  endtask

  task automatic send_random();
    shortint x, y, z;
    shortint edges[5] = '{-32768, 32767, 0, 1, -1};
    case ($urandom_range(3))
      0: begin x = 16'($urandom); y = 16'($urandom); z = 16'($urandom); end
      1: begin
        x = edges[$urandom_range(4)]; y = edges[$urandom_range(4)];
        z = ($urandom_range(1)) ? 16'sd0 : edges[$urandom_range(4)];
      end
      default: begin     // typical scene: in front of the camera, modest spread
        x = 16'(int'($urandom_range(0, 4095)) - 2048);
        y = 16'(int'($urandom_range(0, 4095)) - 2048);
        z = 16'($urandom_range(64, 4096));
      end
    endcase
    send_vertex(x, y, z, 1'b0, '0);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (proj_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------- receiver: random stalls plus one long hold-off ----------------
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 11);
    end
  end

  // ---------------- checker ----------------
  always @(posedge clk) begin
    proj_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (proj_q.size() == 0) begin
        $display("MISMATCH t=%0t: result word with nothing expected", $time);
        errors++;
      end else begin
        w = proj_q.pop_front();
        if (out_tdata[15:0] !== w.col) report("raster_column", out_tdata[15:0], w.col);
        if (out_tdata[31:16] !== w.row) report("raster_row", out_tdata[31:16], w.row);
        if (out_tdata[47:32] !== w.dep) report("depth", out_tdata[47:32], w.dep);
        if (out_tuser[0] !== w.zero) report("zero_depth", out_tuser[0], w.zero);
        if (out_tuser[1] !== w.sat) report("saturated", out_tuser[1], w.sat);
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    // reset values: identity rotation, d=1, half 12.5, 100 px/unit, so x=y=0 lands on 1250
    vec_row_t dir[] = '{
      '{0, 0, 256, 1, '{16'sd1250, 16'sd1250, 16'sd256, 1'b0, 1'b0}},
      '{0, 0, 0, 1, '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0}},
      '{100, -100, 0, 1, '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0}},
      '{0, 0, -256, 1, '{16'sd1250, 16'sd1250, -16'sd256, 1'b0, 1'b0}},
      '{0, 0, 32767, 1, '{16'sd1250, 16'sd1250, 16'sd32767, 1'b0, 1'b0}},
      '{0, 0, -32768, 1, '{16'sd1250, 16'sd1250, -16'sd32768, 1'b0, 1'b0}},
      '{32767, 0, 1, 1, '{16'sd32767, 16'sd1250, 16'sd1, 1'b0, 1'b1}},
      '{-32768, 0, 1, 1, '{-16'sd32768, 16'sd1250, 16'sd1, 1'b0, 1'b1}},
      '{32767, 32767, 32767, 0, '0},
      '{-32768, -32768, -32768, 0, '0},
      '{1, -1, 1, 0, '0},
      '{-1, 1, -1, 0, '0},
      '{12345, -23456, 300, 0, '0},
      '{-512, 768, 1024, 0, '0}
    };
    regs = '{rot_x: 48'h1000, rot_y: 48'h1000_0000, rot_z: 48'h1000_0000_0000, trans: '0,
             distance: 8'd1, half_w: 16'd3200, half_h: 16'd3200,
             scale: {16'd1600, 16'd1600}};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir[i]) send_vertex(dir[i].x, dir[i].y, dir[i].z, dir[i].typed, dir[i].e);
    for (int n = 0; n < 130; n++) send_random();
    drain();   // sender pause until every result is back

    for (int ph = 1; ph <= 12; ph++) begin
      load_regs(pick_cfg(ph));
      calm = (ph == 5);   // one phase without any idling
      for (int n = 0; n < 150; n++) begin
        if (ph == 2 && n == 10) hold_token++;   // receiver holds off, sender keeps going
        send_random();
      end
      drain();
    end
    calm = 1'b0;

    repeat (DRAIN) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
